### hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Register map: index of each configuration register (byte address is 4 * index).
    typedef enum logic [2:0] {
        REG_MIN_PULSE = 3'd0,
        REG_MAX_PULSE = 3'd1,
        REG_HOLDOFF   = 3'd2,
        REG_TRIGGER   = 3'd3,
        REG_TIMEOUT   = 3'd4
    } reg_idx_t;

    // Measurement sequencer modes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TRIG = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_BUSY    = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // Configuration register set as seen by the sequencer.
    typedef struct packed {
        logic [15:0] min_pulse_us;
        logic [15:0] max_pulse_us;
        logic [16:0] holdoff_us;
        logic [7:0]  trigger_us;
        logic [21:0] timeout_us;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic        trigger_level;
        logic        done_res;
        status_t     status;
        logic [13:0] dist_mm;
    } res_t;

    // Reset values of the configuration registers.
    localparam logic [15:0] MIN_PULSE_RST = 16'd20;
    localparam logic [15:0] MAX_PULSE_RST = 16'd38000;
    localparam logic [16:0] HOLDOFF_RST   = 17'd60000;
    localparam logic [7:0]  TRIGGER_RST   = 8'd15;
    localparam logic [21:0] TIMEOUT_RST   = 22'd2000000;

    // Saturation limits of the holdoff and timeout counters.
    localparam logic [16:0] HOLD_MAX = 17'h1FFFF;
    localparam logic [21:0] TMO_MAX  = 22'h3FFFFF;

    // distance = width * 10 / 58 = (width * 5) / 29, done as a multiply by
    // ceil(5 * 2^24 / 29) and a shift; exact for every 16-bit width.
    localparam int          DIST_SHIFT = 24;
    localparam logic [21:0] DIST_RECIP = 22'd2892624;
    localparam logic [13:0] DIST_MAX   = 14'd11299;

endpackage

### hdl/uer_cfg.sv
// APB-style configuration register file for the echo ranger.
module uer_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output uer_pkg::cfg_t       cfg
);
    import uer_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    // Register writes; addresses beyond the map are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse_us <= MIN_PULSE_RST;
            cfg_reg.max_pulse_us <= MAX_PULSE_RST;
            cfg_reg.holdoff_us   <= HOLDOFF_RST;
            cfg_reg.trigger_us   <= TRIGGER_RST;
            cfg_reg.timeout_us   <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_PULSE: cfg_reg.min_pulse_us <= pwdata[15:0];
                REG_MAX_PULSE: cfg_reg.max_pulse_us <= pwdata[15:0];
                REG_HOLDOFF:   cfg_reg.holdoff_us   <= pwdata[16:0];
                REG_TRIGGER:   cfg_reg.trigger_us   <= pwdata[7:0];
                REG_TIMEOUT:   cfg_reg.timeout_us   <= pwdata[21:0];
                default:       ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_MIN_PULSE: prdata = {16'd0, cfg_reg.min_pulse_us};
            REG_MAX_PULSE: prdata = {16'd0, cfg_reg.max_pulse_us};
            REG_HOLDOFF:   prdata = {15'd0, cfg_reg.holdoff_us};
            REG_TRIGGER:   prdata = {24'd0, cfg_reg.trigger_us};
            REG_TIMEOUT:   prdata = {10'd0, cfg_reg.timeout_us};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

### hdl/uer_ctrl.sv
// Trigger/echo sequencer: state registers and the per-tick result logic.
module uer_ctrl #(
    parameter int ECHO_COUNT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           echo_level,
    input  logic           start_request,
    input  uer_pkg::cfg_t  cfg,
    output uer_pkg::res_t  res
);
    import uer_pkg::*;

    localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;

    mode_t                      mode_reg, mode_next;
    logic [7:0]                 trig_cnt_reg, trig_cnt_next;
    logic [ECHO_COUNT_BITS-1:0] width_reg, width_next;
    logic [16:0]                hold_cnt_reg, hold_cnt_next;
    logic [21:0]                tmo_cnt_reg, tmo_cnt_next;
    logic                       echo_prev_reg;
    logic                       started_reg, started_next;

    logic        rise, fall, go, trig_active, edge_done, tmo_done, meas_done, in_window;
    logic [21:0] tmo_inc;
    logic [37:0] dist_prod;

    // Edge detection and the holdoff test.
    assign rise        = echo_level && !echo_prev_reg;
    assign fall        = !echo_level && echo_prev_reg;
    assign go          = start_request && (hold_cnt_reg >= cfg.holdoff_us);
    assign trig_active = (mode_reg == MODE_TRIG) && (trig_cnt_reg < cfg.trigger_us);
    assign tmo_inc     = (tmo_cnt_reg < TMO_MAX) ? tmo_cnt_reg + 22'd1 : tmo_cnt_reg;

    // Pulse window check and distance scaling of the held width.
    assign in_window = (width_reg >= ECHO_COUNT_BITS'(cfg.min_pulse_us))
                    && (width_reg <= ECHO_COUNT_BITS'(cfg.max_pulse_us));
    assign dist_prod = 38'(width_reg[15:0]) * 38'(DIST_RECIP);

    // A measurement ends on a falling edge of a started pulse, else on timeout.
    assign edge_done = !rise && !echo_level && fall && started_reg;
    assign tmo_done  = !edge_done && (tmo_inc >= cfg.timeout_us);
    assign meas_done = (mode_reg != MODE_IDLE) && (edge_done || tmo_done);

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (go)
        begin
            mode_next = MODE_TRIG;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE: mode_next = MODE_IDLE;
                MODE_TRIG,
                MODE_WAIT:
                begin
                    if (meas_done)
                        mode_next = MODE_IDLE;
                    else if (!trig_active)
                        mode_next = MODE_WAIT;
                end
                default:   mode_next = MODE_IDLE;
            endcase
        end
    end

    // Counters and the result item.
    always_comb
    begin
        trig_cnt_next = trig_cnt_reg;
        width_next    = width_reg;
        hold_cnt_next = (hold_cnt_reg < HOLD_MAX) ? hold_cnt_reg + 17'd1 : hold_cnt_reg;
        tmo_cnt_next  = tmo_cnt_reg;
        started_next  = started_reg;
        res           = '0;
        if (go)
        begin
            trig_cnt_next     = 8'd1;
            width_next        = '0;
            hold_cnt_next     = '0;
            tmo_cnt_next      = '0;
            started_next      = 1'b0;
            res.trigger_level = 1'b1;
        end
        else if (mode_reg == MODE_IDLE)
        begin
            if (start_request)
            begin
                res.done_res = 1'b1;
                res.status   = ST_BUSY;
            end
        end
        else
        begin
            tmo_cnt_next = tmo_inc;
            if (trig_active)
                trig_cnt_next = trig_cnt_reg + 8'd1;
            if (rise)
            begin
                started_next = 1'b1;
                width_next   = ECHO_COUNT_BITS'(1);
            end
            else if (echo_level && started_reg && (width_reg < ECHO_MAX))
            begin
                width_next = width_reg + ECHO_COUNT_BITS'(1);
            end
            if (meas_done)
            begin
                started_next = 1'b0;
                res.done_res = 1'b1;
                if (tmo_done)
                    res.status = ST_TIMEOUT;
                else if (in_window)
                begin
                    res.status  = ST_OK;
                    res.dist_mm = dist_prod[DIST_SHIFT +: 14];
                end
                else
                    res.status = ST_RANGE;
            end
            else
            begin
                res.trigger_level = trig_active;
                if (start_request)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_BUSY;
                end
            end
        end
    end

    // State registers advance once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            trig_cnt_reg  <= '0;
            width_reg     <= '0;
            hold_cnt_reg  <= HOLD_MAX;
            tmo_cnt_reg   <= '0;
            echo_prev_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            trig_cnt_reg  <= trig_cnt_next;
            width_reg     <= width_next;
            hold_cnt_reg  <= hold_cnt_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            echo_prev_reg <= echo_level;
            started_reg   <= started_next;
        end
    end

    // An accepted start always lands in the trigger phase with holdoff restarted.
    a_go_trig: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && go) |=> (mode_reg == MODE_TRIG && hold_cnt_reg == 17'd0))
        else $error("accepted start did not enter trigger phase");

    // No pulse is being timed while idle.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> !started_reg)
        else $error("echo marked started while idle");

    // A good reading never exceeds the largest in-window distance.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done_res && res.status == ST_OK) |-> (res.dist_mm <= DIST_MAX))
        else $error("distance out of range");

    // While the trigger is high the only report is a refused start.
    a_trig_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.trigger_level |-> (!res.done_res || res.status == ST_BUSY))
        else $error("measurement reported while trigger high");

endmodule

### hdl/uer_out.sv
// Output register stage for the result stream.
module uer_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  uer_pkg::res_t  in_res,
    output logic           out_valid,
    input  logic           out_ready,
    output uer_pkg::res_t  out_res
);
    import uer_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // Take a new item whenever the held one is empty or leaving.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= in_res;
    end

    // An accepted item is always presented on the next cycle.
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg)
        else $error("accepted item not presented");

    // A stalled result is neither lost nor replaced.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

    // Nothing is accepted while a stalled result is held.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken over a stalled result");

endmodule

### hdl/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: config port, sequencer and output stage.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[0] echo_level, tdata[1] start_request
//  m_axis    out        tdata[0] trigger_level, [2:1] status, [16:3] dist_mm;
//                       tuser done_res
//  apb       in/out     five registers at byte addresses 0, 4, 8, 12, 16
//
// One item (one microsecond tick) is taken every cycle while m_axis is not stalled; its result
// appears in the next cycle from the output register, set by the single sequencer pass.
// The distance path is one 16 x 22 multiply ahead of that register.
// Reset leaves the sequencer idle with the holdoff already expired.
// A stall on m_axis holds the result and drops s_axis_tready until it leaves.
module ultrasonic_echo_ranger_top #(
    parameter int ECHO_COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] echo_level, [1] start_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] trigger_level, [2:1] status, [16:3] dist_mm
    output logic        m_axis_tuser,   // [0] done_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uer_pkg::*;

    cfg_t cfg;
    res_t res_comb, res_out;
    logic accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    uer_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    uer_ctrl #(
        .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .echo_level    (s_axis_tdata[0]),
        .start_request (s_axis_tdata[1]),
        .cfg           (cfg),
        .res           (res_comb)
    );

    // Result register.
    uer_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_res    (res_comb),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res_out)
    );

    // Pack the result item onto the stream.
    assign m_axis_tdata = {7'd0, res_out.dist_mm, res_out.status, res_out.trigger_level};
    assign m_axis_tuser = res_out.done_res;

endmodule
